[rtl/cnalu_pkg.sv]
// complex number alu package: opcodes, divider cell record, saturation helpers
// no dependencies
package cnalu_pkg;

	localparam int FRAC_BITS = 16;
	// quotient bits produced by the divider row, one per cell
	localparam int QBITS = 34;
	// width of partial remainder and shifted divisor
	localparam int DW = 64 + QBITS - 1;
	// register stages from start to done: operand stage, setup stage, cells, output stage
	localparam int LATENCY = QBITS + 3;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EQ  = 3'd4,
		OP_NE  = 3'd5
	} op_t;

	typedef struct packed {
		logic [DW-1:0]    rem;
		logic [QBITS-1:0] quo;
		logic             neg;
		logic             ovf;
	} div_part_t;

	typedef struct packed {
		logic          valid;
		logic          is_div;
		logic [31:0]   re;
		logic [31:0]   im;
		logic          cmp;
		logic          dz;
		logic          sat;
		logic [DW-1:0] dvs;
		div_part_t     p_re;
		div_part_t     p_im;
	} cell_t;

	// clip a wide signed value to 32 bits, msb of result is the clip flag
	function automatic logic [32:0] sat_wide(input logic signed [64:0] v);
		logic hi_same;
		begin
			hi_same = (v[64:31] == '0) || (v[64:31] == '1);
			if (hi_same) begin
				sat_wide = {1'b0, v[31:0]};
			end else if (v[64]) begin
				sat_wide = {1'b1, 32'h8000_0000};
			end else begin
				sat_wide = {1'b1, 32'h7FFF_FFFF};
			end
		end
	endfunction

	// signed and saturated quotient part, msb is the clip flag
	function automatic logic [32:0] div_out(input div_part_t p);
		logic clip;
		begin
			if (p.neg) begin
				clip = p.ovf || (p.quo > QBITS'(64'h8000_0000));
				div_out = clip ? {1'b1, 32'h8000_0000} : {1'b0, 32'(-p.quo)};
			end else begin
				clip = p.ovf || (p.quo > QBITS'(64'h7FFF_FFFF));
				div_out = clip ? {1'b1, 32'h7FFF_FFFF} : {1'b0, p.quo[31:0]};
			end
		end
	endfunction

endpackage

[rtl/cnalu_cell.sv]
// one restoring-divide cell: one quotient bit for each part, then hands on
// depends on cnalu_pkg
module cnalu_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  cnalu_pkg::cell_t  cin,
	output cnalu_pkg::cell_t  cout
);

	cnalu_pkg::cell_t nxt;

	function automatic cnalu_pkg::div_part_t step(input cnalu_pkg::div_part_t p,
		input logic [cnalu_pkg::DW-1:0] d);
		cnalu_pkg::div_part_t r;
		begin
			r = p;
			if (p.rem >= d) begin
				r.rem = p.rem - d;
				r.quo = {p.quo[cnalu_pkg::QBITS-2:0], 1'b1};
			end else begin
				r.quo = {p.quo[cnalu_pkg::QBITS-2:0], 1'b0};
			end
			step = r;
		end
	endfunction

	always_comb begin
		nxt = cin;
		nxt.p_re = step(cin.p_re, cin.dvs);
		nxt.p_im = step(cin.p_im, cin.dvs);
		nxt.dvs = cin.dvs >> 1;
	end

	// only the valid bit is cleared, the data just holds during reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout.valid <= 1'b0;
		end else begin
			cout <= nxt;
		end
	end

endmodule

[rtl/complex_number_alu.sv]
// complex number alu top level: operand products, setup, divider cell row, output
// depends on cnalu_pkg and cnalu_cell
//
// channel   direction  signals                                      transfer when
// command   in         start, busy, opcode, a_re, a_im, b_re, b_im  start high, busy low
// result    out        done, res_re, res_im, compare_true,          done high
//                      div_by_zero, saturated
//
// one command per cycle, every opcode runs through the whole pipeline, divider row included
// the divider row has one cell per quotient bit (34 cells)
// busy stays low, the pipeline never stalls and the receiver cannot stall
// reset clears only the valid bits of the pipeline
module complex_number_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               done,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic               compare_true,
	output logic               div_by_zero,
	output logic               saturated
);

	// stage 1: products, sums, compares
	logic               valid_s1;
	logic [2:0]         op_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_r_s1, p_bb_i_s1;
	logic signed [32:0] add_re_s1, add_im_s1, sub_re_s1, sub_im_s1;
	logic               eq_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	// every product is a real 32x32 signed multiply
	always_ff @(posedge clk) begin
		op_s1     <= opcode;
		p_rr_s1   <= a_re * b_re;
		p_ii_s1   <= a_im * b_im;
		p_ri_s1   <= a_re * b_im;
		p_ir_s1   <= a_im * b_re;
		p_bb_r_s1 <= b_re * b_re;
		p_bb_i_s1 <= b_im * b_im;
		add_re_s1 <= 33'(a_re) + 33'(b_re);
		add_im_s1 <= 33'(a_im) + 33'(b_im);
		sub_re_s1 <= 33'(a_re) - 33'(b_re);
		sub_im_s1 <= 33'(a_im) - 33'(b_im);
		eq_s1     <= (a_re == b_re) && (a_im == b_im);
	end

	// stage 2: finish add, sub, mul, compares; set up the divider
	logic signed [64:0]        mul_re_w, mul_im_w, dsum_re, dsum_im;
	logic [63:0]               den, mag_re, mag_im;
	logic [cnalu_pkg::DW:0]    num_re, num_im, den_top;
	logic [32:0]               r_re, r_im;
	cnalu_pkg::cell_t          setup, chain [cnalu_pkg::QBITS+1];

	always_comb begin
		mul_re_w = (65'(p_rr_s1) - 65'(p_ii_s1)) >>> cnalu_pkg::FRAC_BITS;
		mul_im_w = (65'(p_ri_s1) + 65'(p_ir_s1)) >>> cnalu_pkg::FRAC_BITS;
		den      = $unsigned(p_bb_r_s1) + $unsigned(p_bb_i_s1);
		dsum_re  = 65'(p_rr_s1) + 65'(p_ii_s1);
		dsum_im  = 65'(p_ir_s1) - 65'(p_ri_s1);
		mag_re   = dsum_re[64] ? 64'(-dsum_re) : dsum_re[63:0];
		mag_im   = dsum_im[64] ? 64'(-dsum_im) : dsum_im[63:0];
		// numerator is magnitude scaled by the fraction bits
		num_re   = (cnalu_pkg::DW+1)'(mag_re) << cnalu_pkg::FRAC_BITS;
		num_im   = (cnalu_pkg::DW+1)'(mag_im) << cnalu_pkg::FRAC_BITS;
		den_top  = (cnalu_pkg::DW+1)'(den) << cnalu_pkg::QBITS;

		r_re = '0;
		r_im = '0;
		setup = '0;
		setup.valid = valid_s1;
		case (op_s1)
			cnalu_pkg::OP_ADD: begin
				r_re = cnalu_pkg::sat_wide(65'(add_re_s1));
				r_im = cnalu_pkg::sat_wide(65'(add_im_s1));
			end
			cnalu_pkg::OP_SUB: begin
				r_re = cnalu_pkg::sat_wide(65'(sub_re_s1));
				r_im = cnalu_pkg::sat_wide(65'(sub_im_s1));
			end
			cnalu_pkg::OP_MUL: begin
				r_re = cnalu_pkg::sat_wide(mul_re_w);
				r_im = cnalu_pkg::sat_wide(mul_im_w);
			end
			cnalu_pkg::OP_DIV: begin
				// zero divisor: flag only, results stay zero
				setup.dz     = (den == '0);
				setup.is_div = (den != '0);
			end
			cnalu_pkg::OP_EQ: setup.cmp = eq_s1;
			cnalu_pkg::OP_NE: setup.cmp = !eq_s1;
			default: ;
		endcase
		setup.re  = r_re[31:0];
		setup.im  = r_im[31:0];
		setup.sat = r_re[32] | r_im[32];
		setup.dvs = cnalu_pkg::DW'(den) << (cnalu_pkg::QBITS - 1);
		setup.p_re.rem = num_re[cnalu_pkg::DW-1:0];
		setup.p_re.neg = dsum_re[64];
		setup.p_re.ovf = (num_re >= den_top);
		setup.p_im.rem = num_im[cnalu_pkg::DW-1:0];
		setup.p_im.neg = dsum_im[64];
		setup.p_im.ovf = (num_im >= den_top);
	end

	// setup register: only the valid bit is cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0].valid <= 1'b0;
		end else begin
			chain[0] <= setup;
		end
	end

	// divider row: each cell yields one quotient bit of both parts
	for (genvar k = 0; k < cnalu_pkg::QBITS; k++) begin : g_cell
		cnalu_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cin    (chain[k]),
			.cout   (chain[k+1])
		);
	end

	// output stage: sign and clip the quotients, pick the result
	cnalu_pkg::cell_t last;
	logic [32:0]      q_re, q_im;

	assign last = chain[cnalu_pkg::QBITS];
	assign q_re = cnalu_pkg::div_out(last.p_re);
	assign q_im = cnalu_pkg::div_out(last.p_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_re       <= last.is_div ? q_re[31:0] : last.re;
		res_im       <= last.is_div ? q_im[31:0] : last.im;
		saturated    <= last.is_div ? (q_re[32] | q_im[32]) : last.sat;
		compare_true <= last.cmp;
		div_by_zero  <= last.dz;
	end

	// every transfer in comes out again as a done
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(cnalu_pkg::LATENCY) done)
		else $error("command did not complete after pipeline latency");

	// a zero divisor leaves both parts zero and no clip
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_by_zero) |-> (res_re == '0 && res_im == '0 && !saturated))
		else $error("zero divisor result not cleared");

	// a compare result carries no arithmetic result
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && compare_true) |-> (res_re == '0 && res_im == '0 && !saturated
			&& !div_by_zero))
		else $error("compare result mixed with arithmetic flags");

endmodule
